// ===== rtl/subtractive_lagged_random_generator_macros.svh =====
// Assertion macros used by the generator controller.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SLRG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLRG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/slrg_pkg.sv =====
// Shared widths, constants and controller/datapath interface types.
package slrg_pkg;

  localparam int WORD_W    = 31;
  localparam int SEED_W    = 32;
  localparam int DIFF_W    = 33;
  localparam int IDX_W     = 6;
  localparam int PASS_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [IDX_W-1:0] TABLE_LEN    = 6'd55;
  localparam logic [IDX_W-1:0] SCATTER_STEP = 6'd21;
  localparam logic [IDX_W-1:0] SCAT_LAST    = 6'd54;
  localparam logic [IDX_W-1:0] TRAIL_START  = 6'd31;
  localparam logic [IDX_W-1:0] LAG_BACK     = 6'd24;
  localparam logic [IDX_W-1:0] LEAD_START   = 6'd0;
  localparam logic [IDX_W-1:0] FIRST_ENTRY  = 6'd1;
  localparam logic [PASS_W-1:0] LAST_PASS   = 2'd3;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  localparam logic [WORD_W-1:0] SEED_CONST_RST = 31'd161803398;
  localparam logic [WORD_W-1:0] MODULUS_RST    = 31'd1000000000;
  localparam logic [WORD_W-1:0] MODULUS_MIN    = 31'd2;
  localparam logic [WORD_W-1:0] SCAT_NXT_INIT  = 31'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_CONST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 1'b1;

  typedef struct packed {
    logic accept;
    logic diff_ld;
    logic mod_start;
    logic seed_load;
    logic scat;
    logic warm_rd;
    logic warm_wr;
    logic step_rd;
    logic step_wr;
    logic reseed;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic scat_last;
    logic warm_last;
  } sts_t;

endpackage

// ===== rtl/subtractive_lagged_random_generator.sv =====
// Top level of the subtractive lagged random generator.
//
// Usage:
//   Each request on the slave stream (s_tdata = signed 32-bit seed) yields one
//   result on the master stream: m_tdata holds the next random integer below
//   the modulus, m_tuser flags a request that rebuilt the 55-entry lag table.
//   The first request after reset and any request with a negative seed
//   rebuild the table before the result is made.
//   Sequencing: a plain request does its two table reads in the accept cycle,
//   then the difference write; a new request is taken only after that write.
//   A rebuild first runs a bit-serial remainder of the 32-bit dividend, a
//   scatter fill of 54 entries at one table write per cycle and four warm-up
//   passes of 55 entries, each a registered table read, then the write.
//   Reset (rst, synchronous) restores the default seed constant and modulus
//   and marks the table as unbuilt; the table itself is not cleared.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and its table read done, then it waits for space.
//   Configuration: write seed_constant (index 0) or modulus (index 1) on the
//   cfg channel while no request is in flight; cfg_ready is always high.
module subtractive_lagged_random_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] seed
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [30:0] value, [31] zero
  output logic [0:0]                      m_tuser,   // [0] reseeded
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slrg_pkg::WORD_W-1:0]     cfg_data
);

  slrg_pkg::cmd_t              cmd;
  slrg_pkg::sts_t              sts;
  logic [slrg_pkg::WORD_W-1:0] value_out;
  logic                        reseed_out;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  slrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .seed_neg (s_tdata[slrg_pkg::SEED_W-1]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slrg_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .seed       (s_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value_out  (value_out),
    .reseed_out (reseed_out)
  );

  assign m_tdata = {1'b0, value_out};
  assign m_tuser = reseed_out;

endmodule

// ===== rtl/slrg_mod.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module slrg_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [slrg_pkg::DIV_W-1:0]    dividend,
  input  logic [slrg_pkg::WORD_W-1:0]   divisor,
  output logic                          done,
  output logic [slrg_pkg::WORD_W-1:0]   rem
);

  logic                            busy;
  logic [slrg_pkg::DIV_CNT_W-1:0]  cnt;
  logic [slrg_pkg::DIV_W-1:0]      quo;
  logic [slrg_pkg::DIV_W-1:0]      shifted;
  logic [slrg_pkg::DIV_W-1:0]      trial;
  logic [slrg_pkg::WORD_W-1:0]     rem_next;

  // shift in the next dividend bit and subtract the divisor if it fits
  assign shifted  = {rem, quo[slrg_pkg::DIV_W-1]};
  assign trial    = shifted - {1'b0, divisor};
  assign rem_next = (shifted >= {1'b0, divisor}) ? trial[slrg_pkg::WORD_W-1:0]
                                                 : shifted[slrg_pkg::WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == slrg_pkg::DIV_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == slrg_pkg::DIV_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[slrg_pkg::DIV_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

// ===== rtl/slrg_dpath.sv =====
// Datapath: lag table memory, index and rebuild counters, config and output registers.
module slrg_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  slrg_pkg::cmd_t                  cmd,
  output slrg_pkg::sts_t                  sts,
  input  logic [slrg_pkg::SEED_W-1:0]     seed,
  input  logic                            cfg_we,
  input  logic [slrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slrg_pkg::WORD_W-1:0]     cfg_data,
  output logic [slrg_pkg::WORD_W-1:0]     value_out,
  output logic                            reseed_out
);

  localparam int W = slrg_pkg::WORD_W;
  localparam int I = slrg_pkg::IDX_W;

  function automatic logic [W-1:0] wrap_diff(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
    logic [W:0] d0;
    logic [W:0] d1;
    d0 = {1'b0, a} - {1'b0, b};
    d1 = d0 + {1'b0, m};
    return d0[W] ? d1[W-1:0] : d0[W-1:0];
  endfunction

  // configuration
  logic [W-1:0] seed_const;
  logic [W-1:0] modulus;

  // lag table, entries 1..55
  logic [W-1:0] lag_mem [0:slrg_pkg::TABLE_LEN];
  logic [W-1:0] rd_a;
  logic [W-1:0] rd_b;

  logic [slrg_pkg::SEED_W-1:0] seed_mag;
  logic [slrg_pkg::DIFF_W-1:0] diff;
  logic [slrg_pkg::DIFF_W-1:0] diff_neg;
  logic [slrg_pkg::DIV_W-1:0]  dividend;
  logic                        mod_done;
  logic [W-1:0]                mod_rem;

  logic [W-1:0]            cur;
  logic [W-1:0]            nxt;
  logic [I-1:0]            slot;
  logic [I:0]              slot_sum;
  logic [I-1:0]            cnt;
  logic [slrg_pkg::PASS_W-1:0] pass;
  logic [I-1:0]            lead;
  logic [I-1:0]            trail;
  logic [I-1:0]            lead_next;
  logic [I-1:0]            trail_next;
  logic [I-1:0]            other;

  logic         we;
  logic [I-1:0] waddr;
  logic [W-1:0] wdata;
  logic         re;
  logic [I-1:0] raddr_a;
  logic [I-1:0] raddr_b;
  logic [W-1:0] step_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_const <= slrg_pkg::SEED_CONST_RST;
      modulus    <= slrg_pkg::MODULUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slrg_pkg::CFG_SEED_CONST: seed_const <= cfg_data;
        slrg_pkg::CFG_MODULUS: begin
          // a modulus below two acts as two
          modulus <= (cfg_data < slrg_pkg::MODULUS_MIN) ? slrg_pkg::MODULUS_MIN : cfg_data;
        end
        default: ;
      endcase
    end
  end

  // seed magnitude, then |seed_const - |seed||
  assign diff_neg = ~diff + 1'b1;
  assign dividend = diff[slrg_pkg::DIFF_W-1] ? diff_neg[slrg_pkg::DIV_W-1:0]
                                             : diff[slrg_pkg::DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      seed_mag <= seed[slrg_pkg::SEED_W-1] ? (~seed + 1'b1) : seed;
    end
    if (cmd.diff_ld) begin
      diff <= {2'b00, seed_const} - {1'b0, seed_mag};
    end
  end

  slrg_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (dividend),
    .divisor  (modulus),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // index arithmetic
  assign slot_sum   = {1'b0, slot} + {1'b0, slrg_pkg::SCATTER_STEP};
  assign lead_next  = (lead == slrg_pkg::TABLE_LEN) ? slrg_pkg::FIRST_ENTRY : lead + 1'b1;
  assign trail_next = (trail == slrg_pkg::TABLE_LEN) ? slrg_pkg::FIRST_ENTRY : trail + 1'b1;
  assign other      = (cnt > slrg_pkg::LAG_BACK) ? cnt - slrg_pkg::LAG_BACK
                                                 : cnt + slrg_pkg::TRAIL_START;

  assign sts.mod_done  = mod_done;
  assign sts.scat_last = (cnt == slrg_pkg::SCAT_LAST);
  assign sts.warm_last = (cnt == slrg_pkg::TABLE_LEN) && (pass == slrg_pkg::LAST_PASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead  <= slrg_pkg::LEAD_START;
      trail <= slrg_pkg::TRAIL_START;
    end else if (cmd.warm_wr && sts.warm_last) begin
      lead  <= slrg_pkg::LEAD_START;
      trail <= slrg_pkg::TRAIL_START;
    end else if (cmd.step_rd) begin
      lead  <= lead_next;
      trail <= trail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      cur  <= mod_rem;
      nxt  <= slrg_pkg::SCAT_NXT_INIT;
      slot <= slrg_pkg::SCATTER_STEP;
      cnt  <= slrg_pkg::FIRST_ENTRY;
      pass <= '0;
    end else if (cmd.scat) begin
      cur  <= nxt;
      nxt  <= wrap_diff(cur, nxt, modulus);
      slot <= (slot_sum >= {1'b0, slrg_pkg::TABLE_LEN})
              ? slot_sum[I-1:0] - slrg_pkg::TABLE_LEN : slot_sum[I-1:0];
      cnt  <= sts.scat_last ? slrg_pkg::FIRST_ENTRY : cnt + 1'b1;
    end else if (cmd.warm_wr) begin
      if (cnt == slrg_pkg::TABLE_LEN) begin
        cnt  <= slrg_pkg::FIRST_ENTRY;
        pass <= pass + 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign step_val = wrap_diff(rd_a, rd_b, modulus);

  // one write port
  always_comb begin
    we    = 1'b1;
    waddr = cnt;
    wdata = step_val;
    if (cmd.seed_load) begin
      waddr = slrg_pkg::TABLE_LEN;
      wdata = mod_rem;
    end else if (cmd.scat) begin
      waddr = slot;
      wdata = nxt;
    end else if (cmd.warm_wr) begin
      waddr = cnt;
    end else if (cmd.step_wr) begin
      waddr = lead;
    end else begin
      we = 1'b0;
    end
  end

  // two read ports
  assign re      = cmd.warm_rd || cmd.step_rd;
  assign raddr_a = cmd.step_rd ? lead_next : cnt;
  assign raddr_b = cmd.step_rd ? trail_next : other;

  always_ff @(posedge clk) begin
    if (we) begin
      lag_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a <= lag_mem[raddr_a];
      rd_b <= lag_mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_wr) begin
      value_out  <= step_val;
      reseed_out <= cmd.reseed;
    end
  end

endmodule

// ===== rtl/slrg_ctrl.sv =====
// Controller: request sequencing, table rebuild steps and result handshake.
`include "subtractive_lagged_random_generator_macros.svh"

module slrg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           seed_neg,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  slrg_pkg::sts_t sts,
  output slrg_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIFF     = 4'd1;
  localparam logic [3:0] ST_MOD_GO   = 4'd2;
  localparam logic [3:0] ST_MOD_WAIT = 4'd3;
  localparam logic [3:0] ST_SCAT     = 4'd4;
  localparam logic [3:0] ST_WARM_RD  = 4'd5;
  localparam logic [3:0] ST_WARM_WR  = 4'd6;
  localparam logic [3:0] ST_STEP_RD  = 4'd7;
  localparam logic [3:0] ST_STEP_WR  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       initialized;
  logic       reseed;
  logic       need_reseed;
  logic       out_free;

  assign need_reseed = !initialized || seed_neg;
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.reseed = reseed;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (need_reseed) begin
            state_next = ST_DIFF;
          end else begin
            // table read overlaps the accept cycle
            cmd.step_rd = 1'b1;
            state_next  = ST_STEP_WR;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff_ld = 1'b1;
        state_next  = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_next    = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (sts.mod_done) begin
          cmd.seed_load = 1'b1;
          state_next    = ST_SCAT;
        end
      end
      ST_SCAT: begin
        cmd.scat = 1'b1;
        if (sts.scat_last) begin
          state_next = ST_WARM_RD;
        end
      end
      ST_WARM_RD: begin
        cmd.warm_rd = 1'b1;
        state_next  = ST_WARM_WR;
      end
      ST_WARM_WR: begin
        cmd.warm_wr = 1'b1;
        state_next  = sts.warm_last ? ST_STEP_RD : ST_WARM_RD;
      end
      ST_STEP_RD: begin
        cmd.step_rd = 1'b1;
        state_next  = ST_STEP_WR;
      end
      ST_STEP_WR: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.step_wr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      initialized <= 1'b0;
      reseed      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        reseed <= need_reseed;
      end
      if (cmd.warm_wr && sts.warm_last) begin
        initialized <= 1'b1;
      end
      if (cmd.step_wr) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `SLRG_ASSERT_NXT(a_no_back_to_back, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted in consecutive cycles")
  `SLRG_ASSERT_NXT(a_hold_result, clk, rst, (state == ST_STEP_WR) && m_tvalid && !m_tready, (state == ST_STEP_WR) && m_tvalid, "pending result overwritten or dropped")
  `SLRG_ASSERT_IMP(a_step_after_init, clk, rst, cmd.step_wr, initialized, "table step before rebuild finished")
  `SLRG_ASSERT_NXT(a_result_shown, clk, rst, cmd.step_wr, m_tvalid, "table step did not present a result")

endmodule
